// ----- hw/rtl/nsc_pkg.sv -----
package nsc_pkg;

    // Sentence kinds as reported in sentence_kind.
    localparam logic [2:0] KIND_UNKNOWN = 3'd0;
    localparam logic [2:0] KIND_RMC     = 3'd1;
    localparam logic [2:0] KIND_GGA     = 3'd2;
    localparam logic [2:0] KIND_GYRO    = 3'd3;
    localparam logic [2:0] KIND_COMPASS = 3'd4;
    localparam logic [2:0] KIND_BARO    = 3'd5;
    localparam logic [2:0] KIND_ACCEL   = 3'd6;

    // Number of known prefixes and the slots kept for each prefix text.
    localparam int NKINDS       = 6;
    localparam int PREFIX_SLOTS = 16;

    // Prefix position saturates here.
    localparam logic [3:0] POS_MAX = 4'd12;

    // Special characters.
    localparam logic [7:0] CHAR_DOLLAR   = 8'h24;
    localparam logic [7:0] CHAR_STAR     = 8'h2A;
    localparam logic [7:0] CHAR_NEWLINE  = 8'h0A;
    localparam logic [7:0] CHAR_UPPER_A  = 8'h41;
    localparam logic [7:0] CHAR_LOWER_A  = 8'h61;

    // Prefix text after the dollar sign, one row per kind, padded with zeros.
    localparam logic [7:0] PREFIX_TEXT [NKINDS][PREFIX_SLOTS] = '{
        '{"G", "P", "R", "M", "C", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"G", "P", "G", "G", "A", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"P", "A", "A", "G", ",", "D", "A", "T", "A", ",", "G",
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"P", "A", "A", "G", ",", "D", "A", "T", "A", ",", "C",
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"P", "A", "A", "G", ",", "D", "A", "T", "A", ",", "B",
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"P", "A", "A", "G", ",", "D", "A", "T", "A", ",", "T",
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [3:0] PREFIX_LEN [NKINDS] = '{4'd5, 4'd5, 4'd11, 4'd11, 4'd11, 4'd11};

    // Sentence phase, one-hot.
    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_BODY = 3'b010,
        PH_HEX  = 3'b100
    } phase_t;

    // One received character.
    typedef struct packed {
        logic [7:0] rx_byte;
    } rx_item_t;

    // One sentence report.
    typedef struct packed {
        logic [2:0] sentence_kind;
        logic       checksum_match;
        logic       status_valid;
        logic       sentence_accepted;
        logic [7:0] computed_sum;
        logic [7:0] received_sum;
    } report_item_t;

    // Decoded hex digit; bad is set for a character that is no hex digit.
    typedef struct packed {
        logic       bad;
        logic [3:0] value;
    } nibble_t;

    function automatic nibble_t hex_nibble(input logic [7:0] c);
        nibble_t n;
        n.bad   = 1'b0;
        n.value = 4'd0;
        if (c >= "0" && c <= "9")
        begin
            n.value = 4'(c - "0");
        end
        else if (c >= "A" && c <= "F")
        begin
            n.value = 4'(c - "A" + 8'd10);
        end
        else if (c >= "a" && c <= "f")
        begin
            n.value = 4'(c - "a" + 8'd10);
        end
        else
        begin
            n.bad = 1'b1;
        end
        return n;
    endfunction

endpackage

// ----- hw/rtl/nsc_if.sv -----
// Character stream channel.
interface nsc_rx_if
    import nsc_pkg::*;
();
    logic     valid;
    logic     ready;
    rx_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// Sentence report channel.
interface nsc_report_if
    import nsc_pkg::*;
();
    logic         valid;
    logic         ready;
    report_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/nmea_sentence_checker_top.sv -----
// Channel   Direction   Payload                                   Transfer
// rx        in          rx_byte (8)                               valid & ready
// report    out         kind, checks, accepted, both sums (22)    valid & ready
//
// One character is taken per cycle while ready is high; a closing newline
// registers its report in the output register, or in the skid one if stalled.
// The per-character state update is one pass of logic between the sentence
// state registers and the report register.
// Reset clears the sentence state to idle and empties the report stages.
// A stalled report is held in the output register, a second one in a skid
// register; rx drops ready only while the skid register is occupied.
module nmea_sentence_checker_top
    import nsc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    nsc_rx_if.sink             rx,
    nsc_report_if.source       report
);

    phase_t              phase_reg, phase_next;
    logic [7:0]          xor_reg, xor_next;
    logic [3:0]          pos_reg, pos_next;
    logic [NKINDS-1:0]   cand_reg, cand_next;
    logic [7:0]          prev_reg, prev_next;
    logic [7:0]          status_reg, status_next;
    logic [7:0]          hex_reg, hex_next;
    logic [1:0]          digits_reg, digits_next;
    logic                hex_err_reg, hex_err_next;

    logic                out_valid_reg, out_valid_next;
    logic                skid_valid_reg, skid_valid_next;
    report_item_t        out_data_reg, out_data_next;
    report_item_t        skid_data_reg, skid_data_next;

    logic                in_fire;
    logic                out_take;
    logic                produce;
    logic [7:0]          c;
    logic                in_sentence;
    logic [2:0]          kind;
    logic                match;
    logic                status_ok;
    report_item_t        new_report;
    nibble_t             nib;

    assign c           = rx.data.rx_byte;
    assign rx.ready    = !skid_valid_reg;
    assign in_fire     = rx.valid && rx.ready;
    assign out_take    = out_valid_reg && report.ready;
    assign in_sentence = (phase_reg == PH_BODY) || (phase_reg == PH_HEX);
    assign nib         = hex_nibble(c);

    // Kind lookup: lowest-numbered candidate whose whole prefix was seen.
    always_comb
    begin
        kind = KIND_UNKNOWN;
        for (int k = NKINDS - 1; k >= 0; k--)
        begin
            if (cand_reg[k] && pos_reg >= PREFIX_LEN[k])
            begin
                kind = 3'(k + 1);
            end
        end
    end

    // Report built from the state and the closing newline.
    always_comb
    begin
        match = (phase_reg == PH_HEX) && (digits_reg == 2'd2) && !hex_err_reg
                && (hex_reg == xor_reg);
        status_ok = (phase_reg == PH_HEX)
                    && (status_reg == CHAR_UPPER_A || status_reg == CHAR_LOWER_A);
        new_report.sentence_kind     = kind;
        new_report.checksum_match    = match;
        new_report.status_valid      = status_ok;
        new_report.sentence_accepted = (kind != KIND_UNKNOWN) && match
                                       && (kind == KIND_GGA || status_ok);
        new_report.computed_sum      = xor_reg;
        new_report.received_sum      = (phase_reg == PH_HEX) ? hex_reg : 8'd0;
    end

    // Sentence state update for one transferred character.
    always_comb
    begin
        phase_next   = phase_reg;
        xor_next     = xor_reg;
        pos_next     = pos_reg;
        cand_next    = cand_reg;
        prev_next    = prev_reg;
        status_next  = status_reg;
        hex_next     = hex_reg;
        digits_next  = digits_reg;
        hex_err_next = hex_err_reg;
        produce      = 1'b0;

        if (in_fire)
        begin
            if (c == CHAR_DOLLAR)
            begin
                phase_next   = PH_BODY;
                xor_next     = 8'd0;
                pos_next     = 4'd0;
                cand_next    = '1;
                prev_next    = 8'd0;
                status_next  = 8'd0;
                hex_next     = 8'd0;
                digits_next  = 2'd0;
                hex_err_next = 1'b0;
            end
            else if (in_sentence && c == CHAR_NEWLINE)
            begin
                produce    = 1'b1;
                phase_next = PH_IDLE;
            end
            else
            begin
                case (phase_reg)
                    PH_BODY:
                    begin
                        if (c == CHAR_STAR)
                        begin
                            status_next = prev_reg;
                            phase_next  = PH_HEX;
                        end
                        else
                        begin
                            xor_next  = xor_reg ^ c;
                            prev_next = c;
                            if (pos_reg < POS_MAX)
                            begin
                                for (int k = 0; k < NKINDS; k++)
                                begin
                                    if (pos_reg < PREFIX_LEN[k]
                                        && PREFIX_TEXT[k][pos_reg] != c)
                                    begin
                                        cand_next[k] = 1'b0;
                                    end
                                end
                                pos_next = pos_reg + 4'd1;
                            end
                        end
                    end
                    PH_HEX:
                    begin
                        if (digits_reg < 2'd2)
                        begin
                            hex_next    = {hex_reg[3:0], nib.value};
                            digits_next = digits_reg + 2'd1;
                            if (nib.bad)
                            begin
                                hex_err_next = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // Output register with a skid stage behind it.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;

        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (produce)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_data_next  = new_report;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = new_report;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign report.valid = out_valid_reg;
    assign report.data  = out_data_reg;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            xor_reg        <= 8'd0;
            pos_reg        <= 4'd0;
            cand_reg       <= '1;
            prev_reg       <= 8'd0;
            status_reg     <= 8'd0;
            hex_reg        <= 8'd0;
            digits_reg     <= 2'd0;
            hex_err_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            xor_reg        <= xor_next;
            pos_reg        <= pos_next;
            cand_reg       <= cand_next;
            prev_reg       <= prev_next;
            status_reg     <= status_next;
            hex_reg        <= hex_next;
            digits_reg     <= digits_next;
            hex_err_reg    <= hex_err_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Report payload.
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    // The skid stage is only filled behind a waiting report.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds a report while the output register is empty");

    // A newline that closes an open sentence always yields a report.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && in_sentence && c == CHAR_NEWLINE |=> out_valid_reg)
        else $error("closing newline gave no report");

    // Acceptance of a kind other than GGA requires a valid status character.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.sentence_accepted
        && out_data_reg.sentence_kind != KIND_GGA |-> out_data_reg.status_valid)
        else $error("sentence accepted without a valid status");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import nsc_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 20;
    localparam int RANDOM_CHARS = 2000;

    localparam logic [7:0] CHAR_RETURN = 8'h0D;

    // Kind reported for each prefix row of the package table.
    localparam logic [2:0] KIND_OF_ROW [NKINDS] =
        '{KIND_RMC, KIND_GGA, KIND_GYRO, KIND_COMPASS, KIND_BARO, KIND_ACCEL};

    // How a generated sentence is closed after its body.
    typedef enum int {
        TAIL_UPPER,
        TAIL_LOWER,
        TAIL_WRONG_SUM,
        TAIL_BAD_DIGIT,
        TAIL_ONE_DIGIT,
        TAIL_NO_DIGIT,
        TAIL_NO_STAR,
        TAIL_CUT,
        TAIL_JUNK
    } tail_style_t;

    // One character waiting to be sent, with its pacing marks.
    typedef struct {
        logic [7:0] ch;
        bit         wait_empty;
        bit         hold_rx;
        bit         no_gap;
    } plan_item_t;

    logic clk;
    logic rst_n;

    nsc_rx_if     rx_ch();
    nsc_report_if report_ch();

    nmea_sentence_checker_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx_ch),
        .report (report_ch)
    );

    // Characters still to be sent and reports still owed by the block.
    plan_item_t   rx_plan[$];
    report_item_t due_reports[$];

    // Marks applied to the next planned character.
    bit pending_wait;
    bit pending_hold;
    bit burst_fill;
    int planned_chars;
    logic [7:0] body_sum;

    // Sentence state as the block should hold it.
    phase_t     sent_phase   = PH_IDLE;
    logic [7:0] sent_xor     = 8'h00;
    logic [3:0] sent_pos     = 4'd0;
    logic [5:0] sent_cands   = 6'h3F;
    logic [7:0] sent_prev    = 8'h00;
    logic [7:0] sent_status  = 8'h00;
    logic [7:0] sent_hex     = 8'h00;
    logic [1:0] sent_digits  = 2'd0;
    logic       sent_hex_bad = 1'b0;

    // Handshake bookkeeping shared between the clock edges.
    bit rx_taken;
    bit report_taken;
    int hold_requests;
    int holds_done;
    int hold_left;
    int stall_left;
    int gap_left;
    bit sender_pauses = 1'b1;
    bit receiver_pauses = 1'b1;
    plan_item_t next_item;

    // Results and statistics.
    int errors;
    int cycle_count;
    int chars_taken;
    int reports_checked;
    int reports_accepted;
    int sums_failed;
    int status_missing;
    logic [6:0] kinds_seen = '0;
    report_item_t oldest_due;
    report_item_t seen_report;

    // Value of a checksum digit; bit 4 flags a character that is no hex digit.
    function automatic logic [4:0] digit_value(input logic [7:0] c);
        logic [7:0] folded;
        folded = c | 8'h20;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            return {1'b0, c[3:0]};
        end
        if (folded >= CHAR_LOWER_A && folded <= CHAR_LOWER_A + 8'd5)
        begin
            return {1'b0, 4'(folded - CHAR_LOWER_A + 8'd10)};
        end
        return 5'b1_0000;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 4'd10)
        begin
            return 8'h30 + 8'(n);
        end
        return (lower ? CHAR_LOWER_A : CHAR_UPPER_A) + 8'(n - 4'd10);
    endfunction

    // Random body character; mostly printable, never a dollar or newline.
    function automatic logic [7:0] field_char(input bit allow_star);
        logic [7:0] c;
        do
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                c = 8'($urandom_range(32, 126));
            end
            else
            begin
                c = 8'($urandom_range(0, 255));
            end
        end while (c == CHAR_DOLLAR || c == CHAR_NEWLINE || (!allow_star && c == CHAR_STAR));
        return c;
    endfunction

    // Follows one accepted character and queues the report it closes, if any.
    task automatic track_sentence_char(input logic [7:0] c);
        report_item_t rep;
        logic [4:0] dig;
        logic [2:0] kind;
        logic in_hex;
        if (c == CHAR_DOLLAR)
        begin
            sent_phase   = PH_BODY;
            sent_xor     = 8'h00;
            sent_pos     = 4'd0;
            sent_cands   = 6'h3F;
            sent_prev    = 8'h00;
            sent_status  = 8'h00;
            sent_hex     = 8'h00;
            sent_digits  = 2'd0;
            sent_hex_bad = 1'b0;
        end
        else if (sent_phase == PH_BODY || sent_phase == PH_HEX)
        begin
            if (c == CHAR_NEWLINE)
            begin
                // The first prefix still standing and fully seen decides the kind.
                kind = KIND_UNKNOWN;
                for (int k = NKINDS - 1; k >= 0; k--)
                begin
                    if (sent_cands[k] && sent_pos >= PREFIX_LEN[k])
                    begin
                        kind = KIND_OF_ROW[k];
                    end
                end
                in_hex = (sent_phase == PH_HEX);
                rep.sentence_kind     = kind;
                rep.checksum_match    = in_hex && sent_digits == 2'd2 && !sent_hex_bad &&
                                        sent_hex == sent_xor;
                rep.status_valid      = in_hex && (sent_status == CHAR_UPPER_A ||
                                                   sent_status == CHAR_LOWER_A);
                rep.sentence_accepted = kind != KIND_UNKNOWN && rep.checksum_match &&
                                        (kind == KIND_GGA || rep.status_valid);
                rep.computed_sum      = sent_xor;
                rep.received_sum      = in_hex ? sent_hex : 8'h00;
                due_reports.push_back(rep);
                sent_phase = PH_IDLE;
            end
            else if (sent_phase == PH_BODY)
            begin
                if (c == CHAR_STAR)
                begin
                    sent_status = sent_prev;
                    sent_phase  = PH_HEX;
                end
                else
                begin
                    sent_xor  = sent_xor ^ c;
                    sent_prev = c;
                    if (sent_pos < POS_MAX)
                    begin
                        for (int k = 0; k < NKINDS; k++)
                        begin
                            if (sent_pos < PREFIX_LEN[k] && PREFIX_TEXT[k][sent_pos] != c)
                            begin
                                sent_cands[k] = 1'b0;
                            end
                        end
                        sent_pos++;
                    end
                end
            end
            else if (sent_digits < 2'd2)
            begin
                // A bad digit still takes a slot and shifts in a zero nibble.
                dig = digit_value(c);
                sent_hex_bad = sent_hex_bad | dig[4];
                sent_hex     = {sent_hex[3:0], dig[3:0]};
                sent_digits++;
            end
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    task automatic plan_char(input logic [7:0] c);
        plan_item_t it;
        it.ch         = c;
        it.wait_empty = pending_wait;
        it.hold_rx    = pending_hold;
        it.no_gap     = burst_fill;
        pending_wait  = 1'b0;
        pending_hold  = 1'b0;
        rx_plan.push_back(it);
        planned_chars++;
    endtask

    task automatic plan_body_char(input logic [7:0] c);
        plan_char(c);
        body_sum = body_sum ^ c;
    endtask

    task automatic start_sentence(input string head);
        plan_char(CHAR_DOLLAR);
        body_sum = 8'h00;
        for (int i = 0; i < head.len(); i++)
        begin
            plan_body_char(head[i]);
        end
    endtask

    task automatic finish_sentence(input tail_style_t style);
        logic [7:0] shown;
        logic [7:0] bad;
        logic [4:0] dig;
        shown = body_sum;
        if (style == TAIL_WRONG_SUM)
        begin
            shown = body_sum ^ 8'($urandom_range(1, 255));
        end
        if (style != TAIL_NO_STAR && style != TAIL_CUT)
        begin
            plan_char(CHAR_STAR);
        end
        case (style)
            TAIL_UPPER, TAIL_WRONG_SUM, TAIL_JUNK:
            begin
                plan_char(hex_char(shown[7:4], 1'b0));
                plan_char(hex_char(shown[3:0], 1'b0));
            end
            TAIL_LOWER:
            begin
                plan_char(hex_char(shown[7:4], 1'b1));
                plan_char(hex_char(shown[3:0], 1'b1));
            end
            TAIL_ONE_DIGIT:
            begin
                plan_char(hex_char(shown[7:4], 1'($urandom_range(0, 1))));
            end
            TAIL_BAD_DIGIT:
            begin
                do
                begin
                    bad = field_char(1'b1);
                    dig = digit_value(bad);
                end while (!dig[4]);
                if ($urandom_range(0, 1) != 0)
                begin
                    plan_char(bad);
                    plan_char(hex_char(shown[3:0], 1'b0));
                end
                else
                begin
                    plan_char(hex_char(shown[7:4], 1'b0));
                    plan_char(bad);
                end
            end
            default:
            begin
            end
        endcase
        if (style == TAIL_JUNK)
        begin
            repeat ($urandom_range(1, 3)) plan_char(field_char(1'b1));
        end
        if (style == TAIL_UPPER)
        begin
            plan_char(CHAR_RETURN);
        end
        if (style != TAIL_CUT)
        begin
            plan_char(CHAR_NEWLINE);
        end
    endtask

    // Random sentence: up to two body chars or a known prefix, at times damaged, fields, status; then tail.
    task automatic plan_random_sentence(input bit short_form);
        logic [7:0] head[$];
        int row;
        int pick;
        tail_style_t style;
        start_sentence("");
        if (short_form)
        begin
            repeat ($urandom_range(0, 2)) plan_body_char(field_char(1'b0));
        end
        else
        begin
            row = $urandom_range(0, NKINDS - 1);
            for (int i = 0; i < PREFIX_LEN[row]; i++)
            begin
                head.push_back(PREFIX_TEXT[row][i]);
            end
            if ($urandom_range(0, 4) == 0)
            begin
                head[$urandom_range(0, head.size() - 1)] = field_char(1'b0);
            end
            if ($urandom_range(0, 5) == 0)
            begin
                repeat ($urandom_range(1, head.size() - 1)) void'(head.pop_back());
            end
            foreach (head[i])
            begin
                plan_body_char(head[i]);
            end
            repeat ($urandom_range(0, 3))
            begin
                plan_body_char(",");
                repeat ($urandom_range(0, 6)) plan_body_char(field_char(1'b0));
            end
            if ($urandom_range(0, 4) != 0)
            begin
                plan_body_char(",");
                case ($urandom_range(0, 3))
                    0: plan_body_char(CHAR_UPPER_A);
                    1: plan_body_char(CHAR_LOWER_A);
                    2: plan_body_char("V");
                    default: plan_body_char(field_char(1'b0));
                endcase
            end
        end
        pick = $urandom_range(0, 19);
        if (pick < 6)
            style = TAIL_UPPER;
        else if (pick < 11)
            style = TAIL_LOWER;
        else if (pick == 11)
            style = TAIL_WRONG_SUM;
        else if (pick == 12)
            style = TAIL_BAD_DIGIT;
        else if (pick == 13)
            style = TAIL_ONE_DIGIT;
        else if (pick == 14)
            style = TAIL_NO_DIGIT;
        else if (pick == 15)
            style = TAIL_NO_STAR;
        else if (pick == 16)
            style = TAIL_CUT;
        else
            style = TAIL_JUNK;
        finish_sentence(style);
        // Line noise between sentences, ignored unless it opens or closes one.
        if ($urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 4)) plan_char(8'($urandom_range(0, 255)));
        end
    endtask

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Cycle limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    // Monitor: follow every character transfer and check every report transfer.
    always @(posedge clk)
    begin
        rx_taken     = rst_n && ((rx_ch.valid && rx_ch.ready) === 1'b1);
        report_taken = rst_n && ((report_ch.valid && report_ch.ready) === 1'b1);
        if (rx_taken)
        begin
            chars_taken++;
            track_sentence_char(rx_ch.data.rx_byte);
        end
        if (report_taken)
        begin
            seen_report = report_ch.data;
            if (due_reports.size() == 0)
            begin
                errors++;
                $display("%0t: report with none expected, expected nothing actual %h",
                         $time, seen_report);
            end
            else
            begin
                oldest_due = due_reports.pop_front();
                check_field("sentence_kind", 8'(oldest_due.sentence_kind),
                            8'(seen_report.sentence_kind));
                check_field("checksum_match", 8'(oldest_due.checksum_match),
                            8'(seen_report.checksum_match));
                check_field("status_valid", 8'(oldest_due.status_valid),
                            8'(seen_report.status_valid));
                check_field("sentence_accepted", 8'(oldest_due.sentence_accepted),
                            8'(seen_report.sentence_accepted));
                check_field("computed_sum", oldest_due.computed_sum,
                            seen_report.computed_sum);
                check_field("received_sum", oldest_due.received_sum,
                            seen_report.received_sum);
                reports_checked++;
                reports_accepted += int'(oldest_due.sentence_accepted);
                sums_failed      += int'(!oldest_due.checksum_match);
                status_missing   += int'(!oldest_due.status_valid);
                kinds_seen[oldest_due.sentence_kind] = 1'b1;
            end
        end
    end

    // Driver: offer planned characters with random gaps and drain pauses.
    always @(negedge clk)
    begin
        if (rst_n && !(rx_ch.valid && !rx_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                rx_ch.valid <= 1'b0;
            end
            else if (rx_plan.size() == 0 ||
                     (rx_plan[0].wait_empty && due_reports.size() != 0))
            begin
                rx_ch.valid <= 1'b0;
            end
            else
            begin
                next_item = rx_plan.pop_front();
                rx_ch.data.rx_byte <= next_item.ch;
                rx_ch.valid <= 1'b1;
                if (next_item.hold_rx)
                begin
                    hold_requests <= hold_requests + 1;
                end
                if ($urandom_range(0, 63) == 0)
                begin
                    sender_pauses = !sender_pauses;
                end
                gap_left = (next_item.no_gap || !sender_pauses) ? 0 : $urandom_range(0, 15);
            end
        end
    end

    // Receiver: random stalls per report, plus one long hold when asked.
    always @(negedge clk)
    begin
        if (hold_requests != holds_done)
        begin
            holds_done = hold_requests;
            hold_left  = HOLD_CYCLES;
        end
        if (report_taken)
        begin
            if ($urandom_range(0, 31) == 0)
            begin
                receiver_pauses = !receiver_pauses;
            end
            stall_left = receiver_pauses ? $urandom_range(0, 15) : 0;
        end
        if (!rst_n)
        begin
            report_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            report_ch.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            report_ch.ready <= 1'b0;
        end
        else
        begin
            report_ch.ready <= 1'b1;
        end
    end

    // Stimulus plan, reset and end of run.
    initial
    begin
        int start_chars;
        rst_n = 1'b0;
        rx_ch.valid = 1'b0;
        rx_ch.data = '0;
        report_ch.ready = 1'b0;

        // Characters while idle are ignored, a newline included.
        plan_char(CHAR_NEWLINE);
        plan_char(8'h00);
        plan_char(8'hFF);
        plan_char(CHAR_UPPER_A);

        // Every kind with good checksums in both cases.
        start_sentence("GPRMC,1,A");
        finish_sentence(TAIL_UPPER);
        start_sentence("GPGGA,2,V");
        finish_sentence(TAIL_LOWER);
        start_sentence("PAAG,DATA,G,a");
        finish_sentence(TAIL_UPPER);
        start_sentence("PAAG,DATA,C,A");
        finish_sentence(TAIL_LOWER);
        start_sentence("PAAG,DATA,B,a");
        finish_sentence(TAIL_UPPER);
        start_sentence("PAAG,DATA,T,A");
        finish_sentence(TAIL_UPPER);

        // Bad status, unknown prefixes and a prefix region past its limit.
        start_sentence("PAAG,DATA,C,V");
        finish_sentence(TAIL_UPPER);
        start_sentence("GPRMX,A");
        finish_sentence(TAIL_UPPER);
        start_sentence("PAAG,DATA");
        finish_sentence(TAIL_UPPER);
        start_sentence("PAAG,DATA,BXYZW,A");
        finish_sentence(TAIL_UPPER);

        // Checksum corners: no asterisk, asterisk first, bad and missing digits.
        start_sentence("GPRMC,A");
        finish_sentence(TAIL_NO_STAR);
        start_sentence("");
        finish_sentence(TAIL_UPPER);
        start_sentence("GPGGA,A");
        finish_sentence(TAIL_BAD_DIGIT);
        start_sentence("GPRMC,A");
        plan_char(CHAR_STAR);
        plan_char(CHAR_STAR);
        plan_char("1");
        plan_char(CHAR_NEWLINE);
        start_sentence("GPRMC,A");
        finish_sentence(TAIL_ONE_DIGIT);
        start_sentence("GPGGA,A");
        finish_sentence(TAIL_NO_DIGIT);
        start_sentence("GPGGA,1");
        finish_sentence(TAIL_JUNK);
        start_sentence("PAAG,DATA,T,A");
        finish_sentence(TAIL_WRONG_SUM);

        // A dollar inside an open sentence restarts it.
        start_sentence("GPRMC,A");
        finish_sentence(TAIL_CUT);
        start_sentence("GPGGA,A");
        finish_sentence(TAIL_UPPER);

        // Extreme body bytes and checksums of FF and 00.
        start_sentence("GPGGA,");
        plan_body_char(8'h00);
        plan_body_char(8'hFF);
        plan_body_char(body_sum ^ 8'hFF);
        finish_sentence(TAIL_UPPER);
        start_sentence("GPGGA,z");
        finish_sentence(TAIL_UPPER);

        // Drain, then a burst of short sentences against a long report hold.
        pending_wait = 1'b1;
        pending_hold = 1'b1;
        burst_fill   = 1'b1;
        repeat (25) plan_random_sentence(1'b1);
        burst_fill   = 1'b0;
        pending_wait = 1'b1;

        // Random sentences with occasional drain pauses.
        start_chars = planned_chars;
        while (planned_chars - start_chars < RANDOM_CHARS)
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                pending_wait = 1'b1;
            end
            plan_random_sentence($urandom_range(0, 9) == 0);
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (rx_plan.size() != 0 || rx_ch.valid || due_reports.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d characters and %0d reports: %0d accepted, %0d failed checksums,",
                 chars_taken, reports_checked, reports_accepted, sums_failed);
        $display("%0d without valid status; kinds reported (bit per kind) %b, with stalls.",
                 status_missing, kinds_seen);
        if (errors == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
